[hw/rtl/prf_pkg.sv]
package prf_pkg;

  // Operand width and the depth of the cofactor store.
  localparam int W       = 32;
  localparam int MAX_COF = 9;
  localparam int CW      = $clog2(MAX_COF + 1);
  localparam int IW      = $clog2(MAX_COF);
  localparam int SW      = $clog2(W);

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_cmd_t;

endpackage

[hw/rtl/prf_if.sv]
interface prf_req_if import prf_pkg::*; ();
  logic         valid;
  logic         ready;
  logic [W-1:0] prime_value;
  modport source(output valid, output prime_value, input ready);
  modport sink(input valid, input prime_value, output ready);
endinterface

interface prf_rsp_if import prf_pkg::*; ();
  logic         valid;
  logic         ready;
  logic [W-1:0] root;
  logic         no_root;
  modport source(output valid, output root, output no_root, input ready);
  modport sink(input valid, input root, input no_root, output ready);
endinterface

[hw/rtl/prf_unit.sv]
// Shared bit-serial unit: restoring division (a / m) or interleaved
// modular multiplication (a * b mod m), one bit per cycle.
module prf_unit import prf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  unit_cmd_t    cmd,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] rem,
  output logic [W-1:0] quo
);

  logic          busy;
  logic [SW-1:0] cnt;
  unit_op_t      op;
  logic [W-1:0]  acc;
  logic [W-1:0]  sh;
  logic [W-1:0]  ar;
  logic [W-1:0]  mr;

  logic [W+1:0]  t;
  logic [W+1:0]  s1;
  logic [W+1:0]  s2;
  logic          ge1;

  // The running value stays below m, so one step needs at most two subtracts.
  always_comb begin
    t   = {1'b0, acc, (op == OP_DIV) & sh[W-1]}
        + (((op == OP_MUL) && sh[W-1]) ? {2'b00, ar} : '0);
    ge1 = (t >= {2'b00, mr});
    s1  = ge1 ? (t - {2'b00, mr}) : t;
    s2  = (s1 >= {2'b00, mr}) ? (s1 - {2'b00, mr}) : s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= cmd.op;
        acc  <= '0;
        sh   <= (cmd.op == OP_MUL) ? b : a;
        ar   <= a;
        mr   <= m;
      end else if (busy) begin
        acc <= s2[W-1:0];
        sh  <= {sh[W-2:0], (op == OP_DIV) & ge1};
        cnt <= cnt + 1'b1;
        if (cnt == SW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = acc;
  assign quo = sh;

endmodule

[hw/rtl/primitive_root_finder_top.sv]
// Channel  Dir  Payload                 Beat when
// req      in   prime_value[31:0]       req.valid && req.ready
// rsp      out  root[31:0], no_root     rsp.valid && rsp.ready
//
// One beat on req gives exactly one beat on rsp.
// Each division or modular multiply runs in the shared serial unit.
// Factoring p-1 tries odd trial divisors up to the square root of the part
// still unfactored; each candidate takes up to one modular exponentiation
// per stored cofactor. Inputs below 3 are answered without the unit.
// Reset is synchronous and active high; the cofactor store is not cleared.
// req.ready is high only while the sequencer is idle; a finished result
// waits in the output register, so a new beat may be taken meanwhile.
module primitive_root_finder_top import prf_pkg::*; (
  input  logic clk,
  input  logic rst,
  prf_req_if.sink   req,
  prf_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HALVE,
    S_TRIAL_GO,
    S_TRIAL_W,
    S_STORE_GO,
    S_STORE_W,
    S_CAND_INIT,
    S_TEST,
    S_POW,
    S_MUL_W,
    S_SQ_GO,
    S_SQ_W,
    S_DONE
  } state_t;

  state_t        state;
  logic [W-1:0]  p;
  logic [W-1:0]  phi;
  logic [W-1:0]  remaining;
  logic [W-1:0]  trial;
  logic [W-1:0]  dsr;
  logic          hit;
  logic          last;
  logic [W-1:0]  cof [MAX_COF];
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [W-1:0]  cand;
  logic [W-1:0]  expo;
  logic [W-1:0]  pacc;
  logic [W-1:0]  base;
  logic [W-1:0]  res_root;
  logic          res_flag;
  logic          out_valid;
  logic [W-1:0]  out_root;
  logic          out_flag;

  unit_cmd_t     ucmd;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;
  logic [W-1:0]  um;
  logic          udone;
  logic [W-1:0]  urem;
  logic [W-1:0]  uquo;

  prf_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ucmd),
    .a    (ua),
    .b    (ub),
    .m    (um),
    .done (udone),
    .rem  (urem),
    .quo  (uquo)
  );

  // Operand selection for the shared unit: trial division of the
  // remaining part, cofactor division of p-1, and the two multiplies of
  // square-and-multiply exponentiation.
  always_comb begin
    ucmd = '{start: 1'b0, op: OP_DIV};
    ua   = remaining;
    ub   = base;
    um   = trial;
    case (state)
      S_TRIAL_GO: begin
        ucmd.start = 1'b1;
      end
      S_STORE_GO: begin
        ucmd.start = 1'b1;
        ua         = phi;
        um         = dsr;
      end
      S_POW: begin
        ucmd = '{start: (expo != '0) && expo[0], op: OP_MUL};
        ua   = pacc;
        um   = p;
      end
      S_SQ_GO: begin
        ucmd = '{start: (expo[W-1:1] != '0), op: OP_MUL};
        ua   = base;
        um   = p;
      end
      default: begin
      end
    endcase
  end

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.root    = out_root;
  assign rsp.no_root = out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      remaining <= '0;
      trial     <= '0;
      cand      <= '0;
      pacc      <= W'(1);
    end else begin
      // In S_DONE the output register is managed by that state alone.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            p         <= req.prime_value;
            phi       <= req.prime_value - 1'b1;
            remaining <= req.prime_value - 1'b1;
            count     <= '0;
            if (req.prime_value < W'(2)) begin
              res_root <= '0;
              res_flag <= 1'b1;
              state    <= S_DONE;
            end else if (req.prime_value == W'(2)) begin
              res_root <= W'(1);
              res_flag <= 1'b0;
              state    <= S_DONE;
            end else begin
              state <= S_HALVE;
            end
          end
        end
        // Strip the factors of two one shift per cycle.
        S_HALVE: begin
          if (!remaining[0]) begin
            remaining <= remaining >> 1;
          end else begin
            if (!phi[0] && (count < CW'(MAX_COF))) begin
              cof[count[IW-1:0]] <= phi >> 1;
              count              <= count + 1'b1;
            end
            trial <= W'(3);
            hit   <= 1'b0;
            last  <= 1'b0;
            state <= S_TRIAL_GO;
          end
        end
        S_TRIAL_GO: begin
          state <= S_TRIAL_W;
        end
        // The quotient doubles as the loop bound: trial^2 <= remaining
        // exactly when trial <= remaining / trial.
        S_TRIAL_W: begin
          if (udone) begin
            if (hit) begin
              if (urem == '0) begin
                remaining <= uquo;
                state     <= S_TRIAL_GO;
              end else begin
                dsr   <= trial;
                state <= S_STORE_GO;
              end
            end else if (uquo < trial) begin
              if (remaining > W'(1)) begin
                dsr   <= remaining;
                last  <= 1'b1;
                state <= S_STORE_GO;
              end else begin
                state <= S_CAND_INIT;
              end
            end else if (urem == '0) begin
              remaining <= uquo;
              hit       <= 1'b1;
              state     <= S_TRIAL_GO;
            end else begin
              trial <= trial + W'(2);
              state <= S_TRIAL_GO;
            end
          end
        end
        S_STORE_GO: begin
          state <= S_STORE_W;
        end
        S_STORE_W: begin
          if (udone) begin
            if (count < CW'(MAX_COF)) begin
              cof[count[IW-1:0]] <= uquo;
              count              <= count + 1'b1;
            end
            if (last) begin
              remaining <= W'(1);
              state     <= S_CAND_INIT;
            end else begin
              trial <= trial + W'(2);
              hit   <= 1'b0;
              state <= S_TRIAL_GO;
            end
          end
        end
        S_CAND_INIT: begin
          cand  <= W'(2);
          idx   <= '0;
          state <= S_TEST;
        end
        S_TEST: begin
          if (idx == count) begin
            if (count != '0) begin
              res_root <= cand;
              res_flag <= 1'b0;
              state    <= S_DONE;
            end else if (cand + 1'b1 == p) begin
              res_root <= '0;
              res_flag <= 1'b1;
              state    <= S_DONE;
            end else begin
              cand <= cand + 1'b1;
            end
          end else begin
            expo  <= cof[idx[IW-1:0]];
            pacc  <= W'(1);
            base  <= cand;
            state <= S_POW;
          end
        end
        S_POW: begin
          if (expo == '0) begin
            if (pacc == W'(1)) begin
              idx <= '0;
              if (cand + 1'b1 == p) begin
                res_root <= '0;
                res_flag <= 1'b1;
                state    <= S_DONE;
              end else begin
                cand  <= cand + 1'b1;
                state <= S_TEST;
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_TEST;
            end
          end else if (expo[0]) begin
            state <= S_MUL_W;
          end else begin
            state <= S_SQ_GO;
          end
        end
        S_MUL_W: begin
          if (udone) begin
            pacc  <= urem;
            state <= S_SQ_GO;
          end
        end
        // The last squaring is never used, so it is skipped.
        S_SQ_GO: begin
          if (expo[W-1:1] == '0) begin
            expo  <= '0;
            state <= S_POW;
          end else begin
            state <= S_SQ_W;
          end
        end
        S_SQ_W: begin
          if (udone) begin
            base  <= urem;
            expo  <= expo >> 1;
            state <= S_POW;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_root  <= res_root;
            out_flag  <= res_flag;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A beat on req starts work, so the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready stayed high after an accepted beat");

  // The cofactor store never overfills.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_COF))
    else $error("cofactor count beyond store depth");

  // A result is held back, not dropped, while the previous one waits.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp.valid && !rsp.ready) |=> (state == S_DONE))
    else $error("result overwrote a waiting beat");

  // The shared unit is never started on consecutive cycles.
  a_unit_start: assert property (@(posedge clk) disable iff (rst)
    ucmd.start |=> !ucmd.start)
    else $error("shared unit restarted while running");

endmodule
